/* hw/rtl/ptw_pkg.sv */
// Shared types and constants for the page table walker.
// No dependencies; used by ptw_front, ptw_back and page_table_walker_unit.
package ptw_pkg;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_1G = 2'd2;

   localparam int unsigned VA_W    = 48;
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned ENTRY_W = 64;
   localparam int unsigned FRAME_W = 40;
   localparam int unsigned TIDX_W  = 9;
   localparam int unsigned WORD_W  = FRAME_W + TIDX_W;
   localparam int unsigned BASE_W  = 52;
   localparam int unsigned PS_BIT  = 7;

   localparam int unsigned REQ_DATA_W = 128;
   localparam int unsigned RSP_DATA_W = 56;

   typedef struct packed {
      logic                 is_trans;
      logic                 wr_ok;
      logic [VA_W-1:0]      virt_addr;
      logic [IDX_W-1:0]     entry_index;
      logic [ENTRY_W-1:0]   entry_data;
   } item_type;

endpackage

/* hw/rtl/ptw_front.sv */
// Front end of the page table walker: accepts request transfers, classifies
// them and holds them in a two-entry queue. Depends on ptw_pkg.
module ptw_front #(
   parameter int unsigned TABLE_WORDS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptw_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   output logic                                q_valid,
   input  logic                                q_ready,
   output ptw_pkg::item_type                   q_item
);

   ptw_pkg::item_type q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push, pop;
   ptw_pkg::item_type new_item;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_item     = q_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_trans    = (req_tuser == ptw_pkg::CMD_TRANSLATE);
      new_item.virt_addr   = req_tdata[47:0];
      new_item.entry_index = req_tdata[59:48];
      new_item.entry_data  = req_tdata[123:60];
      new_item.wr_ok       = ({20'd0, req_tdata[59:48]} < 32'(TABLE_WORDS));
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hw/rtl/ptw_back.sv */
// Back end of the page table walker: table store, walk sequencer and result
// register. Depends on ptw_pkg; fed by ptw_front.
module ptw_back #(
   parameter int unsigned TABLE_WORDS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ptw_pkg::FRAME_W-1:0]         root_frame,
   input  logic                                q_valid,
   output logic                                q_ready,
   input  ptw_pkg::item_type                   q_item,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int unsigned AW = $clog2(TABLE_WORDS);
   localparam logic [ptw_pkg::WORD_W-1:0] WORDS_LIM = ptw_pkg::WORD_W'(TABLE_WORDS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_RESULT = 2'd2;

   logic [ptw_pkg::ENTRY_W-1:0] mem [TABLE_WORDS];

   logic [1:0]                      state_ff, state_in;
   logic [1:0]                      lvl_ff, lvl_in;
   logic [ptw_pkg::VA_W-1:0]        va_ff, va_in;
   logic [ptw_pkg::ENTRY_W-1:0]     mem_rd_ff;
   logic [ptw_pkg::BASE_W-1:0]      res_base_ff, res_base_in;
   logic [1:0]                      res_code_ff, res_code_in;
   logic                            res_fault_ff, res_fault_in;
   logic                            res_trans_ff, res_trans_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ptw_pkg::BASE_W-1:0]      rsp_base_ff;
   logic [1:0]                      rsp_code_ff;
   logic                            rsp_fault_ff;
   logic                            rsp_trans_ff;

   logic                            pop, out_free, load_rsp;
   logic [ptw_pkg::FRAME_W-1:0]     rd_frame;
   logic [ptw_pkg::TIDX_W-1:0]      rd_idx;
   logic [ptw_pkg::WORD_W-1:0]      rd_word;
   logic                            in_range, rd_en, mem_we;
   logic                            size_bit;
   logic [ptw_pkg::BASE_W-1:0]      leaf_base;

   assign q_ready  = (state_ff == ST_IDLE);
   assign pop      = q_valid && q_ready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_rsp = (state_ff == ST_RESULT) && out_free;
   assign mem_we   = pop && !q_item.is_trans && q_item.wr_ok;

   assign size_bit  = mem_rd_ff[ptw_pkg::PS_BIT];
   assign leaf_base = {mem_rd_ff[51:12], 12'd0};
   assign rd_word   = {rd_frame, rd_idx};
   assign in_range  = (rd_word < WORDS_LIM);

   always_comb begin
      rd_frame = mem_rd_ff[51:12];
      rd_idx   = va_ff[38:30];
      if (state_ff == ST_IDLE) begin
         rd_frame = root_frame;
         rd_idx   = q_item.virt_addr[47:39];
      end else begin
         case (lvl_ff)
            2'd0:    rd_idx = va_ff[38:30];
            2'd1:    rd_idx = va_ff[29:21];
            default: rd_idx = va_ff[20:12];
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      va_in        = va_ff;
      res_base_in  = res_base_ff;
      res_code_in  = res_code_ff;
      res_fault_in = res_fault_ff;
      res_trans_in = res_trans_ff;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               va_in        = q_item.virt_addr;
               lvl_in       = 2'd0;
               res_base_in  = '0;
               res_code_in  = ptw_pkg::SIZE_4K;
               res_fault_in = 1'b0;
               res_trans_in = q_item.is_trans;
               if (!q_item.is_trans) begin
                  state_in = ST_RESULT;
               end else if (!in_range) begin
                  res_fault_in = 1'b1;
                  state_in     = ST_RESULT;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (lvl_ff == 2'd3) begin
               res_base_in = leaf_base;
               res_code_in = ptw_pkg::SIZE_4K;
               state_in    = ST_RESULT;
            end else if (size_bit && lvl_ff == 2'd1) begin
               res_base_in = leaf_base;
               res_code_in = ptw_pkg::SIZE_1G;
               state_in    = ST_RESULT;
            end else if (size_bit && lvl_ff == 2'd2) begin
               res_base_in = leaf_base;
               res_code_in = ptw_pkg::SIZE_2M;
               state_in    = ST_RESULT;
            end else if (!in_range) begin
               res_fault_in = 1'b1;
               state_in     = ST_RESULT;
            end else begin
               rd_en  = 1'b1;
               lvl_in = lvl_ff + 2'd1;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff        <= va_in;
      res_base_ff  <= res_base_in;
      res_code_ff  <= res_code_in;
      res_fault_ff <= res_fault_in;
      res_trans_ff <= res_trans_in;
      if (load_rsp) begin
         rsp_base_ff  <= res_base_ff;
         rsp_code_ff  <= res_code_ff;
         rsp_fault_ff <= res_fault_ff;
         rsp_trans_ff <= res_trans_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(q_item.entry_index)] <= q_item.entry_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_word[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_fault_ff, rsp_code_ff, rsp_base_ff};
   assign rsp_tuser  = rsp_trans_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("queue popped while walker busy");

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_trans_ff) |-> (rsp_base_ff == '0 && rsp_code_ff == 2'd0
                                           && !rsp_fault_ff))
      else $error("write acknowledge carries nonzero fields");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_base_ff == '0 && rsp_code_ff == 2'd0))
      else $error("faulted walk carries nonzero fields");

   a_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_code_ff != 2'd3)
      else $error("illegal page size code");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("result lost on load");

endmodule

/* hw/rtl/page_table_walker_unit.sv */
// A write is queued, written to the table store and acknowledged through the result
// register; a translation makes one dependent store read per level (up to four) between
// the queue and the result. The walker serves one item at a time, so the queue holds the
// next request while a walk runs; a new item is taken only once the last result is loaded.
// Reset clears control state and the root frame; the table store is not cleared.
// Top level: root frame register, ptw_front and ptw_back. Depends on ptw_pkg.
module page_table_walker_unit #(
   parameter int unsigned TABLE_WORDS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [47:0] virt_addr, [59:48] entry_index, [123:60] entry_data, [127:124] zero
   input  logic [ptw_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [0] command
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [51:0] phys_frame_base, [53:52] page_size_code, [54] walk_fault, [55] zero
   output logic [ptw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] is_translation
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ptw_pkg::FRAME_W-1:0]         csr_data
);

   logic [ptw_pkg::FRAME_W-1:0] root_ff, root_in;
   logic                        q_valid, q_ready;
   ptw_pkg::item_type           q_item;

   assign csr_ready = 1'b1;
   assign root_in   = (csr_valid && csr_ready) ? csr_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   ptw_front #(.TABLE_WORDS(TABLE_WORDS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   ptw_back #(.TABLE_WORDS(TABLE_WORDS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .root_frame (root_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
